/* src/pal_pkg.sv */
// pal_pkg: types, sizes and command codes for the positional array list
// used by pal_cell and positional_array_list; no dependencies
`default_nettype none

package pal_pkg;

  // list geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // fixed field widths of the words on the ports
  localparam int CMD_W   = 2;
  localparam int POS_W   = 5;
  localparam int ENTRY_W = 32;
  localparam int LEN_W   = 5;

  // width that holds both a position and a count plus one without overflow
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  // operation broadcast along the row of cells
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic [IDX_W-1:0]      idx;
    logic [DATA_WIDTH-1:0] word;
  } cell_ctrl_t;

  typedef struct packed {
    cmd_t               command;
    logic [POS_W-1:0]   position;
    logic [ENTRY_W-1:0] entry_data;
  } in_word_t;

  typedef struct packed {
    logic               ok;
    logic [ENTRY_W-1:0] read_data;
    logic [LEN_W-1:0]   length;
    logic               is_empty;
    logic               is_full;
  } out_word_t;

endpackage

`default_nettype wire

/* src/pal_cell.sv */
// pal_cell: one slot of the list, holding a single entry
// takes its neighbors' entries on insert and remove; uses pal_pkg
`default_nettype none

module pal_cell (
  input  logic                           clk,
  input  logic [pal_pkg::IDX_W-1:0]      my_idx,
  input  pal_pkg::cell_ctrl_t            ctrl,
  input  logic [pal_pkg::DATA_WIDTH-1:0] left_data,
  input  logic [pal_pkg::DATA_WIDTH-1:0] right_data,
  output logic [pal_pkg::DATA_WIDTH-1:0] data
);
  import pal_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  // insert: load at the target slot, shift up above it
  // remove: every slot from the target upward takes its right neighbor
  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      CELL_INSERT: begin
        if (my_idx == ctrl.idx) begin
          data_nxt = ctrl.word;
        end else if (my_idx > ctrl.idx) begin
          data_nxt = left_data;
        end
      end
      CELL_REMOVE: begin
        if (my_idx >= ctrl.idx) begin
          data_nxt = right_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

/* src/positional_array_list.sv */
// positional_array_list: top level of the bounded list with positional edits
// builds a row of pal_cell slots and the command decode; uses pal_pkg
`default_nettype none

// A bounded list of up to DEPTH words kept in a row of cells, position 1 in
// the first cell. Append, insert (positions 1 to length+1), remove and read
// (positions 1 to length) each complete on acceptance: the whole row shifts in
// the cycle the word is accepted, and the result is registered on the out_
// side. A new word is accepted every cycle as long as the result register is
// empty or being taken, so the rate is one word per cycle, set by the single
// registered result slot. Refused commands leave the list unchanged and
// report ok low. Reset clears only the length and out_valid, not the cells.

module positional_array_list (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pal_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pal_pkg::out_word_t out_data
);
  import pal_pkg::*;

  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  out_word_t             out_data_r;
  out_word_t             out_data_nxt;
  logic                  accept;
  cell_ctrl_t            ctrl;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [CMP_W-1:0]      pos_w;
  logic [CMP_W-1:0]      cnt_w;
  logic                  not_full;
  logic                  pos_in_list;
  logic                  pos_ins_ok;
  logic [IDX_W-1:0]      pos_idx;
  logic                  ok;
  logic [DATA_WIDTH-1:0] rd_word;

  // handshake: take a word when the result slot is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // position checks
  assign pos_w       = CMP_W'(in_data.position);
  assign cnt_w       = CMP_W'(count_r);
  assign not_full    = (cnt_w < CMP_W'(DEPTH));
  assign pos_in_list = (pos_w != '0) && (pos_w <= cnt_w);
  assign pos_ins_ok  = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1)) && not_full;
  assign pos_idx     = IDX_W'(pos_w - CMP_W'(1));

  // command decode into the broadcast for the cell row
  always_comb begin
    ctrl.op   = CELL_HOLD;
    ctrl.idx  = pos_idx;
    ctrl.word = DATA_WIDTH'(in_data.entry_data);
    ok        = 1'b0;
    count_nxt = count_r;
    case (in_data.command)
      CMD_APPEND: begin
        ok       = not_full;
        ctrl.idx = IDX_W'(count_r);
      end
      CMD_INSERT: begin
        ok = pos_ins_ok;
      end
      CMD_REMOVE: begin
        ok = pos_in_list;
      end
      default: begin
        ok = pos_in_list;
      end
    endcase
    if (accept && ok) begin
      case (in_data.command)
        CMD_APPEND, CMD_INSERT: begin
          ctrl.op   = CELL_INSERT;
          count_nxt = count_r + CNT_W'(1);
        end
        CMD_REMOVE: begin
          ctrl.op   = CELL_REMOVE;
          count_nxt = count_r - CNT_W'(1);
        end
        default: begin
          ctrl.op = CELL_HOLD;
        end
      endcase
    end
  end

  // row of cells, each fed by both neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    pal_cell u_cell (
      .clk        (clk),
      .my_idx     (IDX_W'(g)),
      .ctrl       (ctrl),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[g])
    );
  end

  // read tap at the addressed slot
  assign rd_word = cell_data[pos_idx];

  // result word
  always_comb begin
    out_data_nxt.ok        = ok;
    out_data_nxt.read_data = (ok && in_data.command == CMD_READ) ?
                             ENTRY_W'(rd_word) : '0;
    out_data_nxt.length    = LEN_W'(count_nxt);
    out_data_nxt.is_empty  = (count_nxt == '0);
    out_data_nxt.is_full   = (count_nxt == CNT_W'(DEPTH));
    out_valid_nxt          = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
